@@ rtl/ppc_pkg.sv @@
// Shared types and constants for the patch post compositor.
// Used by ppc_front, ppc_back, the top level and the checker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ppc_pkg;

   // Field widths fixed by the word format
   localparam int DATA_W      = 8;
   localparam int ADDR_W      = 20;
   localparam int DIM_REG_W   = 11;
   localparam int ORIGIN_W    = 16;
   localparam int ROW_W       = 9;
   localparam int LEFT_W      = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Queue depth between parser and address unit
   localparam int FIFO_DEPTH = 4;

   // Defaults for the top-level parameters
   localparam int DEFAULT_MAX_TEX_DIM       = 1024;
   localparam int DEFAULT_MAX_PATCH_COLUMNS = 1024;

   // Column terminator in the top offset position
   localparam logic [DATA_W-1:0] END_MARK = 8'hFF;

   // Register indexes on the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_TEX_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEX_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_X   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_Y   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FILL_INDEX = 3'd4;

   // Register reset values
   localparam logic [DIM_REG_W-1:0] TEX_DIM_RESET = 11'd64;

   // Parser phases
   typedef enum logic [2:0] {
      PH_TOP  = 3'd0,
      PH_LEN  = 3'd1,
      PH_PAD1 = 3'd2,
      PH_PIX  = 3'd3,
      PH_PAD2 = 3'd4
   } ppc_phase_type;

   // Configuration handed to the address unit
   typedef struct packed {
      logic        [DIM_REG_W-1:0] tex_width;
      logic        [DIM_REG_W-1:0] tex_height;
      logic signed [ORIGIN_W-1:0]  origin_x;
      logic signed [ORIGIN_W-1:0]  origin_y;
      logic        [DATA_W-1:0]    fill_index;
   } ppc_cfg_type;

endpackage

`default_nettype wire

@@ rtl/ppc_fifo.sv @@
// Small register queue between the post parser and the address unit.
// Depends on nothing; width and depth come from parameters.
`timescale 1ns / 1ps
`default_nettype none

module ppc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output      logic             full,
   input  wire logic             pop,
   output      logic             not_empty,
   output      logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // Advance pointers and the fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming word
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ rtl/ppc_front.sv @@
// Post parser: walks top offset, length, pads and pixels of each column.
// Depends on ppc_pkg; pushes one word per placed pixel into the queue.
`timescale 1ns / 1ps
`default_nettype none

module ppc_front
   import ppc_pkg::*;
#(
   parameter int MAX_PATCH_COLUMNS = DEFAULT_MAX_PATCH_COLUMNS,
   localparam int COL_W = $clog2(MAX_PATCH_COLUMNS + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire logic [DATA_W-1:0] req_data_byte,
   input  wire logic              req_patch_begin,
   input  wire logic              fifo_full,
   output      logic              push,
   output      logic [COL_W-1:0]  push_col,
   output      logic [ROW_W-1:0]  push_row,
   output      logic [DATA_W-1:0] push_value
);

   localparam logic [COL_W-1:0] COL_LIMIT = COL_W'(MAX_PATCH_COLUMNS);

   ppc_phase_type     phase_ff, phase_in, cur_phase;
   logic [LEFT_W-1:0] left_ff, left_in, cur_left, left_dec;
   logic [COL_W-1:0]  col_ff, col_in, cur_col;
   logic [ROW_W-1:0]  row_ff, row_in, cur_row;
   logic              accept, col_open;

   assign req_stall = fifo_full;
   assign accept    = req_valid && !fifo_full;

   // Clear parser state on the first byte of a patch
   assign cur_phase = req_patch_begin ? PH_TOP : phase_ff;
   assign cur_left  = req_patch_begin ? '0 : left_ff;
   assign cur_col   = req_patch_begin ? '0 : col_ff;
   assign cur_row   = req_patch_begin ? '0 : row_ff;
   assign left_dec  = cur_left - LEFT_W'(1);
   assign col_open  = (cur_col < COL_LIMIT);

   assign push_col   = cur_col;
   assign push_row   = cur_row;
   assign push_value = req_data_byte;

   // Next phase and counters
   always_comb begin
      phase_in = phase_ff;
      left_in  = left_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      push     = 1'b0;
      if (accept) begin
         left_in = cur_left;
         col_in  = cur_col;
         row_in  = cur_row;
         unique case (cur_phase)
            PH_LEN: begin
               left_in  = req_data_byte;
               phase_in = PH_PAD1;
            end
            PH_PAD1: begin
               phase_in = (cur_left != '0) ? PH_PIX : PH_PAD2;
            end
            PH_PIX: begin
               push     = col_open;
               row_in   = cur_row + ROW_W'(1);
               left_in  = left_dec;
               phase_in = (left_dec == '0) ? PH_PAD2 : PH_PIX;
            end
            PH_PAD2: begin
               phase_in = PH_TOP;
            end
            default: begin
               if (req_data_byte == END_MARK) begin
                  if (col_open) begin
                     col_in = cur_col + COL_W'(1);
                  end
                  phase_in = PH_TOP;
               end else begin
                  row_in   = ROW_W'(req_data_byte);
                  phase_in = PH_LEN;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TOP;
         left_ff  <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/ppc_back.sv @@
// Address unit: clips pixels to the texture and forms column * height + row.
// Depends on ppc_pkg; drains the queue through a range stage and an output stage.
`timescale 1ns / 1ps
`default_nettype none

module ppc_back
   import ppc_pkg::*;
#(
   parameter int MAX_TEX_DIM       = DEFAULT_MAX_TEX_DIM,
   parameter int MAX_PATCH_COLUMNS = DEFAULT_MAX_PATCH_COLUMNS,
   localparam int COL_W = $clog2(MAX_PATCH_COLUMNS + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ppc_cfg_type       cfg,
   input  wire logic              q_valid,
   output      logic              q_pop,
   input  wire logic [COL_W-1:0]  q_col,
   input  wire logic [ROW_W-1:0]  q_row,
   input  wire logic [DATA_W-1:0] q_value,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      logic [ADDR_W-1:0] rsp_write_addr,
   output      logic [DATA_W-1:0] rsp_write_value
);

   localparam int DIM_W = $clog2(MAX_TEX_DIM + 1);
   localparam int SW    = ((COL_W > ORIGIN_W) ? COL_W : ORIGIN_W) + 2;
   localparam int AW    = 2 * DIM_W + 1;
   localparam int PW    = (AW > ADDR_W) ? AW : ADDR_W;
   localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_TEX_DIM);

   logic [DIM_W-1:0]     w_clamp, h_clamp;
   logic signed [SW-1:0] w_s, h_s, col_s, row_s;
   logic                 in_range;
   logic [PW-1:0]        addr_full;

   logic                 s1_valid_ff, s1_valid_in;
   logic [DIM_W-1:0]     s1_col_ff, s1_row_ff;
   logic [DATA_W-1:0]    s1_value_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]    addr_ff;
   logic [DATA_W-1:0]    value_ff;
   logic                 rsp_ready, s1_ready;

   // Limit texture size to the supported maximum
   assign w_clamp = (32'(cfg.tex_width) > 32'(MAX_TEX_DIM)) ? DIM_MAX : DIM_W'(cfg.tex_width);
   assign h_clamp = (32'(cfg.tex_height) > 32'(MAX_TEX_DIM)) ? DIM_MAX : DIM_W'(cfg.tex_height);
   assign w_s     = SW'(w_clamp);
   assign h_s     = SW'(h_clamp);

   // Place the pixel in texture space and clip it
   assign col_s    = SW'(cfg.origin_x) + $signed(SW'(q_col));
   assign row_s    = SW'(cfg.origin_y) + $signed(SW'(q_row));
   assign in_range = (col_s >= 0) && (col_s < w_s) && (row_s >= 0) && (row_s < h_s);

   // Handshake between stages
   assign rsp_ready = !rsp_valid_ff || !rsp_stall;
   assign s1_ready  = !s1_valid_ff || rsp_ready;
   assign q_pop     = q_valid && s1_ready;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (s1_ready) begin
         s1_valid_in = q_pop && in_range;
      end
      if (rsp_ready) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Range stage: hold clipped coordinates and the substituted value
   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_col_ff   <= col_s[DIM_W-1:0];
         s1_row_ff   <= row_s[DIM_W-1:0];
         s1_value_ff <= (q_value != '0) ? q_value : cfg.fill_index;
      end
   end

   // Output stage: column-major address
   assign addr_full = PW'(s1_col_ff) * PW'(h_clamp) + PW'(s1_row_ff);

   always_ff @(posedge clock) begin
      if (rsp_ready && s1_valid_ff) begin
         addr_ff  <= addr_full[ADDR_W-1:0];
         value_ff <= s1_value_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_write_addr  = addr_ff;
   assign rsp_write_value = value_ff;

endmodule

`default_nettype wire

@@ rtl/patch_post_compositor.sv @@
// Patch post compositor: turns patch column post bytes into texture writes.
//
// Request channel: one post byte per word (req_data_byte), with
// req_patch_begin high on the first byte of each patch. A word is taken when
// req_valid is high and req_stall is low. Response channel: one texture write
// (rsp_write_addr, rsp_write_value) per pixel that lands inside the texture;
// a word leaves when rsp_valid is high and rsp_stall is low.
// Throughput: one request word per cycle while req_stall is low. A pixel's
// byte enters the queue when taken, then passes the clip stage and the address
// stage, which holds one multiply-add; bytes that place no pixel give no word.
// A four-word queue separates the parser from the address unit; when the
// receiver stalls, the output holds, the stages behind it fill, and req_stall
// rises once the queue is full. Configuration is written through
// csr_write_en/csr_index/csr_wdata by the user only while no pixel is in
// flight; the block does not enforce this. Reset clears the parser, empties the
// queue and the stages and restores register defaults (64 x 64 texture, origin
// zero, fill 0). Depends on ppc_pkg, ppc_fifo, ppc_front and ppc_back.
`timescale 1ns / 1ps
`default_nettype none

module patch_post_compositor
   import ppc_pkg::*;
#(
   parameter int MAX_TEX_DIM       = DEFAULT_MAX_TEX_DIM,
   parameter int MAX_PATCH_COLUMNS = DEFAULT_MAX_PATCH_COLUMNS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire logic [DATA_W-1:0]      req_data_byte,
   input  wire logic                   req_patch_begin,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      logic [ADDR_W-1:0]      rsp_write_addr,
   output      logic [DATA_W-1:0]      rsp_write_value,
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int COL_W = $clog2(MAX_PATCH_COLUMNS + 1);
   localparam int Q_W   = COL_W + ROW_W + DATA_W;

   ppc_cfg_type       cfg_ff, cfg_in;
   logic              push, fifo_full, q_valid, q_pop;
   logic [COL_W-1:0]  push_col;
   logic [ROW_W-1:0]  push_row;
   logic [DATA_W-1:0] push_value;
   logic [Q_W-1:0]    q_data;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_TEX_WIDTH:  cfg_in.tex_width  = csr_wdata[DIM_REG_W-1:0];
            CSR_TEX_HEIGHT: cfg_in.tex_height = csr_wdata[DIM_REG_W-1:0];
            CSR_ORIGIN_X:   cfg_in.origin_x   = csr_wdata[ORIGIN_W-1:0];
            CSR_ORIGIN_Y:   cfg_in.origin_y   = csr_wdata[ORIGIN_W-1:0];
            CSR_FILL_INDEX: cfg_in.fill_index = csr_wdata[DATA_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tex_width  <= TEX_DIM_RESET;
         cfg_ff.tex_height <= TEX_DIM_RESET;
         cfg_ff.origin_x   <= '0;
         cfg_ff.origin_y   <= '0;
         cfg_ff.fill_index <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ppc_front #(
      .MAX_PATCH_COLUMNS(MAX_PATCH_COLUMNS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_patch_begin(req_patch_begin),
      .fifo_full      (fifo_full),
      .push           (push),
      .push_col       (push_col),
      .push_row       (push_row),
      .push_value     (push_value)
   );

   ppc_fifo #(
      .WIDTH(Q_W),
      .DEPTH(FIFO_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data({push_col, push_row, push_value}),
      .full     (fifo_full),
      .pop      (q_pop),
      .not_empty(q_valid),
      .pop_data (q_data)
   );

   ppc_back #(
      .MAX_TEX_DIM      (MAX_TEX_DIM),
      .MAX_PATCH_COLUMNS(MAX_PATCH_COLUMNS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .q_valid        (q_valid),
      .q_pop          (q_pop),
      .q_col          (q_data[Q_W-1 -: COL_W]),
      .q_row          (q_data[DATA_W +: ROW_W]),
      .q_value        (q_data[DATA_W-1:0]),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_write_addr (rsp_write_addr),
      .rsp_write_value(rsp_write_value)
   );

endmodule

`default_nettype wire

@@ rtl/ppc_checker.sv @@
// Port-level checks for the patch post compositor, bound to the top level.
// Depends on ppc_pkg and on patch_post_compositor's port list.
`timescale 1ns / 1ps
`default_nettype none

module ppc_checker
   import ppc_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic [ADDR_W-1:0] rsp_write_addr,
   input wire logic [DATA_W-1:0] rsp_write_value
);

   // Hold a stalled response word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_write_addr)
                                 && $stable(rsp_write_value))
      else $error("response word changed while stalled");

   // No write can emerge straight after reset
   a_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid ##1 !rsp_valid)
      else $error("response word too soon after reset");

   // Input backpressure only follows a blocked output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> $past(rsp_valid && rsp_stall))
      else $error("request stalled without output backpressure");

   // A stalled request always has a write waiting at the output
   a_stall_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |-> rsp_valid)
      else $error("request stalled with no write pending");

endmodule

bind patch_post_compositor ppc_checker u_ppc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_write_addr (rsp_write_addr),
   .rsp_write_value(rsp_write_value)
);

`default_nettype wire
